>>> design/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the coherence directory table
// Holds the coherence state, request mode and error codes, the layout of a
// stored directory entry and the configuration register set.
// ----------------------------------------------------------------------------
package cdt_pkg;

	localparam int CDT_ENTRIES   = 64;
	localparam int CDT_MAX_PROCS = 16;
	localparam int CDT_TAG_W     = 48;
	localparam int CDT_MASK_W    = 16;
	localparam int CDT_PADDR_W   = 3;
	localparam int CDT_PDATA_W   = 32;

	// Largest processor count the sharer mask can represent.
	localparam logic [4:0] CDT_PROC_LIM =
		5'((CDT_MAX_PROCS < CDT_MASK_W) ? CDT_MAX_PROCS : CDT_MASK_W);

	localparam logic [4:0] CDT_NUM_PROCS_RST = 5'd4;
	localparam logic       CDT_MESI_RST      = 1'b1;

	// Configuration register indexes (byte address is four times the index).
	localparam logic REG_NUM_PROCS = 1'b0;
	localparam logic REG_MESI      = 1'b1;

	typedef enum logic [1:0] {
		ST_UNCACHED  = 2'd0,
		ST_SHARED    = 2'd1,
		ST_EXCLUSIVE = 2'd2,
		ST_MODIFIED  = 2'd3
	} cdt_status_t;

	typedef enum logic [1:0] {
		MODE_LOOKUP = 2'd0,
		MODE_UPDATE = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_SPARE  = 2'd3
	} cdt_mode_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EXCL  = 2'd2,
		ERR_PROC  = 2'd3
	} cdt_err_t;

	typedef struct packed {
		logic [CDT_TAG_W-1:0]  tag;
		cdt_status_t           status;
		logic [CDT_MASK_W-1:0] sharers;
	} cdt_entry_t;

	typedef struct packed {
		logic [4:0] num_procs;
		logic       mesi_enabled;
	} cdt_cfg_t;

endpackage

>>> design/cdt_regs.sv
// ----------------------------------------------------------------------------
// cdt_regs: configuration registers of the coherence directory table
// APB-style slave holding the processor count and the MESI enable.
// ----------------------------------------------------------------------------
module cdt_regs import cdt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CDT_PADDR_W-1:0] paddr,
	input  logic [CDT_PDATA_W-1:0] pwdata,
	output logic [CDT_PDATA_W-1:0] prdata,
	output logic                   pready,
	output cdt_cfg_t               cfg
);

	cdt_cfg_t cfg_q;
	logic     wr_en;
	logic     reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_procs    <= CDT_NUM_PROCS_RST;
			cfg_q.mesi_enabled <= CDT_MESI_RST;
		end else if (wr_en) begin
			if (reg_sel == REG_NUM_PROCS) begin
				cfg_q.num_procs <= pwdata[4:0];
			end else begin
				cfg_q.mesi_enabled <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (reg_sel == REG_NUM_PROCS) begin
			prdata = {{(CDT_PDATA_W-5){1'b0}}, cfg_q.num_procs};
		end else begin
			prdata = {{(CDT_PDATA_W-1){1'b0}}, cfg_q.mesi_enabled};
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/cdt_mem.sv
// ----------------------------------------------------------------------------
// cdt_mem: directory storage
// A valid-bit memory and an entry memory sharing one address, each with a
// registered read port and a write enable of its own.
// ----------------------------------------------------------------------------
module cdt_mem import cdt_pkg::*; #(
	parameter int ENTRIES = CDT_ENTRIES,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic [AW-1:0] addr,
	input  logic          we_vld,
	input  logic          wvld,
	input  logic          we_ent,
	input  cdt_entry_t    wdata,
	output logic          rvld,
	output cdt_entry_t    rdata
);

	logic       vld_mem [ENTRIES];
	cdt_entry_t ent_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we_vld) begin
			vld_mem[addr] <= wvld;
		end
		rvld <= vld_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (we_ent) begin
			ent_mem[addr] <= wdata;
		end
		rdata <= ent_mem[addr];
	end

endmodule

>>> design/cdt_ctrl.sv
// ----------------------------------------------------------------------------
// cdt_ctrl: directory sequencer
// Clears the valid memory after reset, scans the table for the requested
// line and the lowest free slot, then applies the request with at most one write
// and loads the result register.
// ----------------------------------------------------------------------------
module cdt_ctrl import cdt_pkg::*; #(
	parameter int ENTRIES = CDT_ENTRIES,
	parameter int AW      = $clog2(ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdt_cfg_t              cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [CDT_TAG_W-1:0]  line_addr,
	input  logic [1:0]            new_status,
	input  logic [3:0]            proc_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [1:0]            entry_status,
	output logic [CDT_MASK_W-1:0] sharer_mask,
	output logic [1:0]            error,
	output logic [AW-1:0]         mem_addr,
	output logic                  mem_we_vld,
	output logic                  mem_wvld,
	output logic                  mem_we_ent,
	output cdt_entry_t            mem_wdata,
	input  logic                  mem_rvld,
	input  cdt_entry_t            mem_rdata
);

	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_DECIDE = 4'b1000
	} state_t;

	state_t state_q;
	logic [AW-1:0] cnt_q;
	logic          issued_all_q;
	logic          pend_s1;
	logic [AW-1:0] idx_s1;

	// Request captured at acceptance.
	cdt_mode_t            req_mode_q;
	logic [CDT_TAG_W-1:0] req_addr_q;
	cdt_status_t          req_status_q;
	logic [3:0]           req_proc_q;

	// Scan results.
	logic          hit_q;
	logic [AW-1:0] hslot_q;
	cdt_entry_t    hentry_q;
	logic          free_found_q;
	logic [AW-1:0] fslot_q;

	// Result register.
	logic                  out_valid_q;
	logic                  res_hit_q;
	logic [1:0]            res_status_q;
	logic [CDT_MASK_W-1:0] res_mask_q;
	logic [1:0]            res_err_q;

	logic match;
	logic out_free;
	logic finish;

	// Decision outputs.
	logic                  d_we_vld;
	logic                  d_wvld;
	logic                  d_we_ent;
	cdt_entry_t            d_entry;
	logic [AW-1:0]         d_slot;
	cdt_status_t           d_status;
	logic [CDT_MASK_W-1:0] d_mask;
	cdt_err_t              d_err;
	logic [4:0]            eff_procs;
	logic                  proc_ok;
	logic [CDT_MASK_W-1:0] req_bit;

	assign match    = pend_s1 && mem_rvld && (mem_rdata.tag == req_addr_q);
	assign out_free = !out_valid_q || out_ready;
	assign finish   = (state_q == S_DECIDE) && out_free;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		eff_procs = (cfg.num_procs == 5'd0) ? 5'd1 : cfg.num_procs;
		if (eff_procs > CDT_PROC_LIM) begin
			eff_procs = CDT_PROC_LIM;
		end
		proc_ok = ({1'b0, req_proc_q} < eff_procs);
		req_bit = CDT_MASK_W'(1) << req_proc_q;
	end

	always_comb begin
		d_we_vld = 1'b0;
		d_wvld   = 1'b1;
		d_we_ent = 1'b0;
		d_slot   = hit_q ? hslot_q : fslot_q;
		d_entry  = '{tag: req_addr_q, status: ST_UNCACHED, sharers: '0};
		d_err    = ERR_OK;
		if (hit_q) begin
			d_status = hentry_q.status;
			d_mask   = hentry_q.sharers;
		end else begin
			d_status = ST_UNCACHED;
			d_mask   = '0;
		end
		case (req_mode_q)
			MODE_LOOKUP: begin
				if (!hit_q) begin
					if (free_found_q) begin
						d_we_vld = 1'b1;
						d_we_ent = 1'b1;
					end else begin
						d_err = ERR_FULL;
					end
				end
			end
			MODE_UPDATE: begin
				if (!proc_ok) begin
					d_err = ERR_PROC;
				end else if (!hit_q) begin
					if (free_found_q) begin
						d_we_vld = 1'b1;
						d_we_ent = 1'b1;
						d_entry.status  = req_status_q;
						d_entry.sharers = req_bit;
					end else begin
						d_err = ERR_FULL;
					end
				end else begin
					d_entry = hentry_q;
					case (req_status_q)
						ST_SHARED: begin
							d_we_ent        = 1'b1;
							d_entry.status  = ST_SHARED;
							d_entry.sharers = hentry_q.sharers | req_bit;
						end
						ST_EXCLUSIVE: begin
							if (!cfg.mesi_enabled || hentry_q.status != ST_UNCACHED) begin
								d_err = ERR_EXCL;
							end else begin
								d_we_ent        = 1'b1;
								d_entry.status  = ST_EXCLUSIVE;
								d_entry.sharers = req_bit;
							end
						end
						ST_MODIFIED: begin
							d_we_ent        = 1'b1;
							d_entry.status  = ST_MODIFIED;
							d_entry.sharers = req_bit;
						end
						default: begin
							// Uncached frees the slot.
							d_we_vld = 1'b1;
							d_wvld   = 1'b0;
						end
					endcase
				end
				if (d_we_ent) begin
					d_status = d_entry.status;
					d_mask   = d_entry.sharers;
				end else if (d_we_vld && !d_wvld) begin
					d_status = ST_UNCACHED;
					d_mask   = '0;
				end
			end
			default: begin
				// Owner query; the spare mode code behaves the same.
				if (!hit_q) begin
					d_err = ERR_PROC;
				end
			end
		endcase
	end

	always_comb begin
		mem_addr   = cnt_q;
		mem_we_vld = 1'b0;
		mem_wvld   = 1'b0;
		mem_we_ent = 1'b0;
		mem_wdata  = d_entry;
		case (state_q)
			S_CLEAR: begin
				mem_we_vld = 1'b1;
			end
			S_DECIDE: begin
				mem_addr   = d_slot;
				mem_we_vld = finish && d_we_vld;
				mem_wvld   = d_wvld;
				mem_we_ent = finish && d_we_ent;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			issued_all_q <= 1'b0;
			pend_s1      <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cnt_q        <= '0;
						issued_all_q <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					pend_s1 <= !issued_all_q;
					if (!issued_all_q) begin
						if (cnt_q == LAST) begin
							issued_all_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (pend_s1 && !mem_rvld && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (match) begin
						hit_q   <= 1'b1;
						pend_s1 <= 1'b0;
						state_q <= S_DECIDE;
					end else if (pend_s1 && idx_s1 == LAST) begin
						pend_s1 <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_mode_q   <= cdt_mode_t'(mode);
			req_addr_q   <= line_addr;
			req_status_q <= cdt_status_t'(new_status);
			req_proc_q   <= proc_id;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= cnt_q;
			if (pend_s1 && !mem_rvld && !free_found_q) begin
				fslot_q <= idx_s1;
			end
			if (match) begin
				hslot_q  <= idx_s1;
				hentry_q <= mem_rdata;
			end
		end
		if (finish) begin
			res_hit_q    <= hit_q;
			res_status_q <= d_status;
			res_mask_q   <= d_mask;
			res_err_q    <= d_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = res_hit_q;
	assign entry_status = res_status_q;
	assign sharer_mask  = res_mask_q;
	assign error        = res_err_q;

	// The table is only written by the clearing pass or when a decision retires.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we_vld || mem_we_ent) |-> (state_q == S_CLEAR || finish))
		else $error("directory written outside clear or retire");

	// No request is taken before the valid memory has been cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("request accepted during clearing pass");

	// A retired decision always shows up in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (out_valid_q && state_q == S_IDLE))
		else $error("retired decision did not load the result");

	// A new slot is allocated only where the scan saw a free one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(finish && mem_we_vld && mem_wvld) |-> (free_found_q && !hit_q))
		else $error("allocation without a free slot");

endmodule

>>> design/coherence_directory_table_top.sv
// ----------------------------------------------------------------------------
// coherence_directory_table_top: fully associative coherence directory
// Maps a line address to a coherence state and a sharer bit vector, with
// lookup-or-allocate, state update and owner query requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   -----------------------------------------
//  request   in_valid / in_ready       mode, line_addr, new_status, proc_id
//  result    out_valid / out_ready     hit, entry_status, sharer_mask, error
//  config    psel, penable, pready     paddr, pwrite, pwdata, prdata
//
//  A request is handled one at a time. The sequencer scans the entry memory
//  one slot per cycle through its single port, stopping at the slot that
//  holds the line, while a miss scans every slot.
//  After reset a clearing pass invalidates every slot;
//  in_ready stays low during it while configuration writes are taken as usual.
//  The result sits in an output register; a stalled result transfer holds the
//  next request in its decision cycle until the register frees up.
//
module coherence_directory_table_top import cdt_pkg::*; #(
	parameter int ENTRIES = CDT_ENTRIES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CDT_PADDR_W-1:0] paddr,
	input  logic [CDT_PDATA_W-1:0] pwdata,
	output logic [CDT_PDATA_W-1:0] prdata,
	output logic                   pready,
	// Request channel.
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             mode,
	input  logic [CDT_TAG_W-1:0]   line_addr,
	input  logic [1:0]             new_status,
	input  logic [3:0]             proc_id,
	// Result channel.
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [1:0]             entry_status,
	output logic [CDT_MASK_W-1:0]  sharer_mask,
	output logic [1:0]             error
);

	localparam int AW = $clog2(ENTRIES);

	cdt_cfg_t      cfg;
	logic [AW-1:0] mem_addr;
	logic          mem_we_vld;
	logic          mem_wvld;
	logic          mem_we_ent;
	cdt_entry_t    mem_wdata;
	logic          mem_rvld;
	cdt_entry_t    mem_rdata;

	// Register file for the processor count and protocol selection.
	cdt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Valid bits and entries live in two memories addressed together, so a
	// scan step reads both the valid bit and the tag of one slot.
	cdt_mem #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_mem (
		.clk    (clk),
		.addr   (mem_addr),
		.we_vld (mem_we_vld),
		.wvld   (mem_wvld),
		.we_ent (mem_we_ent),
		.wdata  (mem_wdata),
		.rvld   (mem_rvld),
		.rdata  (mem_rdata)
	);

	// The sequencer does the read-modify-write. Requests never overlap, so the
	// write of one request, if any, always lands before the next scan begins.
	cdt_ctrl #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.line_addr    (line_addr),
		.new_status   (new_status),
		.proc_id      (proc_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.entry_status (entry_status),
		.sharer_mask  (sharer_mask),
		.error        (error),
		.mem_addr     (mem_addr),
		.mem_we_vld   (mem_we_vld),
		.mem_wvld     (mem_wvld),
		.mem_we_ent   (mem_we_ent),
		.mem_wdata    (mem_wdata),
		.mem_rvld     (mem_rvld),
		.mem_rdata    (mem_rdata)
	);

endmodule
